// ===== hdl/dvsc_pkg.sv =====
package dvsc_pkg;

  // Width of each timer's down-counter
  localparam int unsigned TimerBits = 16;
  localparam int unsigned NumTimers = 5;
  localparam int unsigned NumOut    = 12;

  // Timer slots, in the order a tick serves them
  localparam logic [2:0] TmrPoll    = 3'd0;
  localparam logic [2:0] TmrTimeout = 3'd1;
  localparam logic [2:0] TmrLeft    = 3'd2;
  localparam logic [2:0] TmrRight   = 3'd3;
  localparam logic [2:0] TmrRecheck = 3'd4;

  localparam logic [3:0] RunMax = 4'd15;

  typedef enum logic [2:0] {
    ActTick   = 3'd0,
    ActOpen   = 3'd1,
    ActClose  = 3'd2,
    ActCheck  = 3'd3,
    ActLock   = 3'd4,
    ActUnlock = 3'd5
  } action_e;

  // Configuration register indexes
  localparam logic [2:0] CfgPollPeriod  = 3'd0;
  localparam logic [2:0] CfgLowRunLimit = 3'd1;
  localparam logic [2:0] CfgTimeout     = 3'd2;
  localparam logic [2:0] CfgLeftDelay   = 3'd3;
  localparam logic [2:0] CfgRightDelay  = 3'd4;
  localparam logic [2:0] CfgRecheck     = 3'd5;

  localparam logic [7:0]  RstPollPeriod  = 8'd5;
  localparam logic [3:0]  RstLowRunLimit = 4'd3;
  localparam logic [15:0] RstTimeout     = 16'd100;
  localparam logic [15:0] RstLeftDelay   = 16'd100;
  localparam logic [15:0] RstRightDelay  = 16'd101;
  localparam logic [15:0] RstRecheck     = 16'd3000;

  localparam logic [32:0] MaxCount = (33'd1 << TimerBits) - 33'd1;

  // Treat zero as one tick, clip to what the counter holds
  function automatic logic [TimerBits-1:0] sat_period(input logic [15:0] p);
    logic [32:0] w;
    w = 33'(p);
    if (w == 33'd0) w = 33'd1;
    if (w > MaxCount) w = MaxCount;
    return TimerBits'(w);
  endfunction

endpackage

// ===== hdl/dual_valve_self_check.sv =====
// Two-motor valve controller with hall-sensor self-test. Each request carries one
// action (tuser: 0 tick, 1 open, 2 close, 3 check, 4 lock, 5 unlock) and the two
// hall levels seen with it; each request yields exactly one result word holding
// drive levels, valve status and the fault/clear events of that request. Ticks
// (nominally 100 ms) advance the five timers: poll, timeout, left final, right
// final and recheck, served in that order within one tick. The block takes one
// request per clock cycle while the result stream does not stall; its result appears
// in the output register on the next cycle, set by the single-pass update logic
// between the request and the result register. A new request is taken while a result
// still waits, as long as the result is taken in the same cycle. Configuration writes go
// through cfg_we_i and must only be made while no result is pending.
module dual_valve_self_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] left_hall, [1] right_hall, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] left_drive, [1] right_drive,
                                        // [2] valve_is_open, [3] valve_usable,
                                        // [4] locked_now, [5] left_alarm,
                                        // [6] right_alarm, [7] command_refused,
                                        // [8] left_fault_event, [9] right_fault_event,
                                        // [10] left_clear_event, [11] right_clear_event
);

  localparam int unsigned TB = dvsc_pkg::TimerBits;
  localparam int unsigned NT = dvsc_pkg::NumTimers;

  // Configuration registers
  logic [7:0]  poll_period_q;
  logic [3:0]  low_run_limit_q;
  logic [15:0] check_timeout_q;
  logic [15:0] left_delay_q;
  logic [15:0] right_delay_q;
  logic [15:0] recheck_delay_q;

  // Controller state
  logic [1:0]    drv_q, drv_d;
  logic          open_q, open_d;
  logic          usable_q, usable_d;
  logic          lock_q, lock_d;
  logic [1:0]    chk_q, chk_d;
  logic [1:0]    seen_q, seen_d;
  logic [3:0]    run_len_q [2];
  logic [3:0]    run_len_d [2];
  logic [1:0]    alarm_q, alarm_d;
  logic [TB-1:0] cnt_q [NT];
  logic [TB-1:0] cnt_d [NT];
  logic [NT-1:0] tmr_on_q, tmr_on_d;

  // Result register
  logic                        out_valid_q;
  logic [dvsc_pkg::NumOut-1:0] res_q, res_d;

  logic          in_acc;
  logic [1:0]    hall;
  logic [TB-1:0] per [NT];

  // Accept whenever the result slot is free or is drained this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign hall            = s_axis_tdata_i[1:0];

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q};

  // Reload values per timer slot
  assign per[dvsc_pkg::TmrPoll]    = dvsc_pkg::sat_period({8'h00, poll_period_q});
  assign per[dvsc_pkg::TmrTimeout] = dvsc_pkg::sat_period(check_timeout_q);
  assign per[dvsc_pkg::TmrLeft]    = dvsc_pkg::sat_period(left_delay_q);
  assign per[dvsc_pkg::TmrRight]   = dvsc_pkg::sat_period(right_delay_q);
  assign per[dvsc_pkg::TmrRecheck] = dvsc_pkg::sat_period(recheck_delay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_period_q   <= dvsc_pkg::RstPollPeriod;
      low_run_limit_q <= dvsc_pkg::RstLowRunLimit;
      check_timeout_q <= dvsc_pkg::RstTimeout;
      left_delay_q    <= dvsc_pkg::RstLeftDelay;
      right_delay_q   <= dvsc_pkg::RstRightDelay;
      recheck_delay_q <= dvsc_pkg::RstRecheck;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dvsc_pkg::CfgPollPeriod:  poll_period_q   <= cfg_wdata_i[7:0];
        dvsc_pkg::CfgLowRunLimit: low_run_limit_q <= cfg_wdata_i[3:0];
        dvsc_pkg::CfgTimeout:     check_timeout_q <= cfg_wdata_i;
        dvsc_pkg::CfgLeftDelay:   left_delay_q    <= cfg_wdata_i;
        dvsc_pkg::CfgRightDelay:  right_delay_q   <= cfg_wdata_i;
        dvsc_pkg::CfgRecheck:     recheck_delay_q <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Single-pass update: the whole action, including the ordered timer sweep
  // of a tick, resolves here and lands in the state and result registers.
  always_comb begin
    logic [NT-1:0] started;
    logic          refused;
    logic [1:0]    fault_ev;
    logic [1:0]    clear_ev;
    logic [2:0]    tix;
    logic [2:0]    fin;
    logic          sd;
    logic          od;

    drv_d     = drv_q;
    open_d    = open_q;
    usable_d  = usable_q;
    lock_d    = lock_q;
    chk_d     = chk_q;
    seen_d    = seen_q;
    run_len_d = run_len_q;
    alarm_d   = alarm_q;
    cnt_d     = cnt_q;
    tmr_on_d  = tmr_on_q;
    started   = '0;
    refused   = 1'b0;
    fault_ev  = 2'b00;
    clear_ev  = 2'b00;
    tix       = '0;
    fin       = '0;
    sd        = 1'b0;
    od        = 1'b0;

    if (in_acc) begin
      unique case (dvsc_pkg::action_e'(s_axis_tuser_i))
        dvsc_pkg::ActTick: begin
          for (int t = 0; t < NT; t++) begin
            tix = 3'(t);
            if (tmr_on_d[tix] && !started[tix]) begin
              if (cnt_d[tix] > TB'(1)) begin
                cnt_d[tix] = cnt_d[tix] - TB'(1);
              end else begin
                // fire: poll reloads itself while a side still checks, the others stop
                cnt_d[tix] = '0;
                if (tix == dvsc_pkg::TmrPoll) cnt_d[tix] = per[tix];
                else tmr_on_d[tix] = 1'b0;
                unique case (tix)
                  dvsc_pkg::TmrPoll: begin
                    for (int s = 0; s < 2; s++) begin
                      sd = 1'(s);
                      if (chk_d[sd] && !seen_d[sd]) begin
                        if (!hall[sd]) begin
                          if (run_len_d[sd] < dvsc_pkg::RunMax)
                            run_len_d[sd] = run_len_d[sd] + 4'd1;
                        end else begin
                          run_len_d[sd] = 4'd0;
                        end
                        if (run_len_d[sd] > low_run_limit_q) begin
                          // low run long enough: reopen and arm final check
                          chk_d[sd]  = 1'b0;
                          seen_d[sd] = 1'b1;
                          drv_d[sd]  = 1'b1;
                          fin = sd ? dvsc_pkg::TmrRight : dvsc_pkg::TmrLeft;
                          cnt_d[fin]    = per[fin];
                          tmr_on_d[fin] = 1'b1;
                          started[fin]  = 1'b1;
                        end
                      end
                    end
                    if (chk_d == 2'b00) tmr_on_d[dvsc_pkg::TmrPoll] = 1'b0;
                  end
                  dvsc_pkg::TmrTimeout: begin
                    for (int s = 0; s < 2; s++) begin
                      sd = 1'(s);
                      if (chk_d[sd] && !seen_d[sd]) begin
                        usable_d    = 1'b0;
                        alarm_d[sd] = 1'b1;
                        chk_d[sd]   = 1'b0;
                        drv_d[sd]   = 1'b1;
                        tmr_on_d[dvsc_pkg::TmrPoll] = 1'b0;
                        fault_ev[sd] = 1'b1;
                      end
                    end
                  end
                  dvsc_pkg::TmrLeft, dvsc_pkg::TmrRight: begin
                    sd = (tix == dvsc_pkg::TmrRight);
                    od = !sd;
                    if (hall[sd]) begin
                      alarm_d[sd] = 1'b0;
                      if (!alarm_d[od]) usable_d = 1'b1;
                      clear_ev[sd] = 1'b1;
                    end else begin
                      usable_d     = 1'b0;
                      alarm_d[sd]  = 1'b1;
                      fault_ev[sd] = 1'b1;
                    end
                  end
                  default: begin
                    // recheck expired: start an automatic self-check
                    run_len_d[0] = 4'd0;
                    run_len_d[1] = 4'd0;
                    chk_d    = 2'b00;
                    seen_d   = 2'b00;
                    tmr_on_d = '0;
                    for (int s = 0; s < 2; s++) begin
                      sd = 1'(s);
                      if (hall[sd]) begin
                        chk_d[sd] = 1'b1;
                        drv_d[sd] = 1'b0;
                        cnt_d[dvsc_pkg::TmrPoll]    = per[dvsc_pkg::TmrPoll];
                        cnt_d[dvsc_pkg::TmrTimeout] = per[dvsc_pkg::TmrTimeout];
                        tmr_on_d[dvsc_pkg::TmrPoll]    = 1'b1;
                        tmr_on_d[dvsc_pkg::TmrTimeout] = 1'b1;
                        started[dvsc_pkg::TmrPoll]     = 1'b1;
                        started[dvsc_pkg::TmrTimeout]  = 1'b1;
                      end
                    end
                  end
                endcase
              end
            end
          end
        end
        dvsc_pkg::ActOpen: begin
          if (lock_q || !usable_q) begin
            refused = 1'b1;
          end else begin
            open_d = 1'b1;
            drv_d  = 2'b11;
            tmr_on_d[dvsc_pkg::TmrPoll]    = 1'b0;
            tmr_on_d[dvsc_pkg::TmrTimeout] = 1'b0;
            tmr_on_d[dvsc_pkg::TmrLeft]    = 1'b0;
            tmr_on_d[dvsc_pkg::TmrRight]   = 1'b0;
            tmr_on_d[dvsc_pkg::TmrRecheck] = 1'b1;
            cnt_d[dvsc_pkg::TmrRecheck]    = per[dvsc_pkg::TmrRecheck];
          end
        end
        dvsc_pkg::ActClose: begin
          // drive low even when refused; keep timers while unusable
          open_d = 1'b0;
          drv_d  = 2'b00;
          if (!usable_q) refused = 1'b1;
          else tmr_on_d = '0;
        end
        dvsc_pkg::ActCheck: begin
          run_len_d[0] = 4'd0;
          run_len_d[1] = 4'd0;
          chk_d    = 2'b00;
          seen_d   = 2'b00;
          tmr_on_d = '0;
          for (int s = 0; s < 2; s++) begin
            sd = 1'(s);
            if (hall[sd]) begin
              chk_d[sd] = 1'b1;
              drv_d[sd] = 1'b0;
              cnt_d[dvsc_pkg::TmrPoll]    = per[dvsc_pkg::TmrPoll];
              cnt_d[dvsc_pkg::TmrTimeout] = per[dvsc_pkg::TmrTimeout];
              tmr_on_d[dvsc_pkg::TmrPoll]    = 1'b1;
              tmr_on_d[dvsc_pkg::TmrTimeout] = 1'b1;
            end
          end
        end
        dvsc_pkg::ActLock:   lock_d = 1'b1;
        dvsc_pkg::ActUnlock: lock_d = 1'b0;
        default: ;  // unknown actions change nothing
      endcase
    end

    res_d = {clear_ev[1], clear_ev[0], fault_ev[1], fault_ev[0], refused,
             alarm_d[1], alarm_d[0], lock_d, usable_d, open_d, drv_d[1], drv_d[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_q        <= 2'b00;
      open_q       <= 1'b0;
      usable_q     <= 1'b1;
      lock_q       <= 1'b0;
      chk_q        <= 2'b00;
      seen_q       <= 2'b00;
      run_len_q[0] <= 4'd0;
      run_len_q[1] <= 4'd0;
      alarm_q      <= 2'b00;
      for (int t = 0; t < NT; t++) cnt_q[t] <= '0;
      tmr_on_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      drv_q       <= drv_d;
      open_q      <= open_d;
      usable_q    <= usable_d;
      lock_q      <= lock_d;
      chk_q       <= chk_d;
      seen_q      <= seen_d;
      run_len_q   <= run_len_d;
      alarm_q     <= alarm_d;
      cnt_q       <= cnt_d;
      tmr_on_q    <= tmr_on_d;
      // hold the result until taken, load a fresh one per request
      out_valid_q <= in_acc || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

`ifndef SYNTHESIS
  // A side is never both still polling and already past its low run
  assert property (@(posedge clk_i) disable iff (!rst_ni) (chk_q & seen_q) == 2'b00)
    else $error("side both checking and seen low");

  // Unusable exactly while some side alarm stands
  assert property (@(posedge clk_i) disable iff (!rst_ni) usable_q == (alarm_q == 2'b00))
    else $error("usable flag disagrees with alarms");

  // The poll timer only runs while some side is still being polled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tmr_on_q[dvsc_pkg::TmrPoll] |-> (chk_q != 2'b00))
    else $error("poll timer running with no side checking");

  // A close request always reports both drives low and the valve closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && (s_axis_tuser_i == dvsc_pkg::ActClose))
                   |=> (m_axis_tdata_o[1:0] == 2'b00) && !m_axis_tdata_o[2])
    else $error("close left a drive high");
`endif

endmodule
